// ----- design/lkv_pkg.sv -----
// Shared types and widths for the LRU key/value cache.
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // Command codes carried on the slave-side tuser.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;

    // Per-cell update strobes.
    typedef struct packed {
        logic shift;   // take the neighbor's contents
        logic clear;   // drop the held pair
    } t_cell_ctl;

endpackage

// ----- design/lkv_cell.sv -----
// One recency-ordered storage cell of the LRU key/value cache.
module lkv_cell
    import lkv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_key      i_nb_key,
    input  t_val      i_nb_value,
    input  logic      i_nb_valid,
    input  t_key      i_cmp_key,
    output t_key      o_key,
    output t_val      o_value,
    output logic      o_valid,
    output logic      o_match
);

    logic r_valid;
    t_key r_key;
    t_val r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_nb_valid;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_cmp_key);

endmodule

// ----- design/lkv_match_sel.sv -----
// Registered reduction of the cell match lines into hit flag, position and value.
module lkv_match_sel
    import lkv_pkg::*;
#(
    parameter int CELLS = 15,
    parameter int POS_W = 4
)
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [CELLS-1:0] i_match,
    input  t_val             i_value [CELLS],
    output logic             o_found,
    output logic [POS_W-1:0] o_pos,
    output t_val             o_value
);

    logic             n_found;
    logic [POS_W-1:0] n_pos;
    t_val             n_value;
    logic             r_found;
    logic [POS_W-1:0] r_pos;
    t_val             r_value;

    // Keys are unique among valid cells, so at most one match line is high.
    always_comb begin
        n_found = |i_match;
        n_pos   = '0;
        n_value = '0;
        for (int i = 0; i < CELLS; i++) begin
            if (i_match[i]) begin
                n_pos   = n_pos | POS_W'(i);
                n_value = n_value | i_value[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_found <= n_found;
            r_pos   <= n_pos;
            r_value <= n_value;
        end
    end

    assign o_found = r_found;
    assign o_pos   = r_pos;
    assign o_value = r_value;

endmodule

// ----- design/lru_key_value_cache_core.sv -----
// Top level of the LRU key/value cache: command sequencer, cell row and result register.
// Flow: command registers, ST_LOOK (match result registered), ST_UPD (cell row and result register).
// New words are taken as an update finishes, not during lookup; a full result register stalls it.
// Reset: all cells go invalid at once; key and value storage is not cleared, no sweep needed.
// Capacity is ENTRIES-1 pairs; cell 0 holds the most recent pair, the last valid cell the oldest.
module lru_key_value_cache_core
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // lookup_key[31:0], store_value[63:32]
    input  logic         s_axis_tuser,   // action[0]: 0 get, 1 put
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // hit[0], read_value[32:1], evicted_valid[33],
                                         // evicted_key[65:34], evicted_value[97:66],
                                         // replaced_valid[98], replaced_value[130:99], zero pad
);

    // One cell per storable pair; a full row means every cell is valid.
    localparam int CELLS = ENTRIES - 1;
    localparam int POS_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int OUT_W = 131;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Command held for the duration of its lookup and update.
    logic r_act;
    t_key r_key;
    t_val r_val;

    // Cell row.
    t_key       w_key   [CELLS];
    t_val       w_value [CELLS];
    logic [CELLS-1:0] w_valid;
    logic [CELLS-1:0] w_match;
    t_cell_ctl  w_ctl   [CELLS];

    // Registered lookup result.
    logic             w_found;
    logic [POS_W-1:0] w_pos;
    t_val             w_mval;

    // Result register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    logic w_in_acc;
    logic w_upd_go;
    logic w_full;
    logic w_full_put;
    logic w_matched;
    logic w_do_shift;
    logic w_shift_all;
    logic w_clear_tail;
    t_val w_front_val;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    // Finish the update only when the result register is free or being drained.
    assign w_upd_go = (r_state == ST_UPD) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == ST_IDLE) || w_upd_go;

    // Capture the command word.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act <= s_axis_tuser;
            r_key <= s_axis_tdata[31:0];
            r_val <= s_axis_tdata[63:32];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_in_acc) begin
                    n_state = ST_LOOK;
                end else if (w_upd_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Compare every cell against the held key; register the single match.
    lkv_match_sel #(
        .CELLS (CELLS),
        .POS_W (POS_W)
    ) u_match_sel (
        .i_clk   (i_clk),
        .i_en    (r_state == ST_LOOK),
        .i_match (w_match),
        .i_value (w_value),
        .o_found (w_found),
        .o_pos   (w_pos),
        .o_value (w_mval)
    );

    // Update decisions. A put on a full row evicts the oldest pair (the last cell)
    // first; if that pair carries the put's key, the put becomes a fresh insert.
    assign w_full      = w_valid[CELLS-1];
    assign w_full_put  = (r_act == ACT_PUT) && w_full;
    assign w_matched   = w_found && !(w_full_put && (w_pos == POS_W'(CELLS - 1)));
    // Get hit or matched put: move the pair to the front. Unmatched put: insert at
    // the front and push everything back by one, the oldest falling off when full.
    assign w_do_shift  = (r_act == ACT_PUT) || w_found;
    assign w_shift_all = (r_act == ACT_PUT) && !w_matched;
    assign w_clear_tail = w_full_put && w_matched;
    assign w_front_val = (r_act == ACT_PUT) ? r_val : w_mval;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        t_key w_nb_key;
        t_val w_nb_value;
        logic w_nb_valid;

        assign w_ctl[g].shift = w_upd_go && w_do_shift &&
                                (w_shift_all || (POS_W'(g) <= w_pos));
        assign w_ctl[g].clear = w_upd_go && w_clear_tail && (g == CELLS - 1);

        if (g == 0) begin : g_head
            assign w_nb_key   = r_key;
            assign w_nb_value = w_front_val;
            assign w_nb_valid = 1'b1;
        end else begin : g_body
            assign w_nb_key   = w_key[g-1];
            assign w_nb_value = w_value[g-1];
            assign w_nb_valid = w_valid[g-1];
        end

        lkv_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_nb_key   (w_nb_key),
            .i_nb_value (w_nb_value),
            .i_nb_valid (w_nb_valid),
            .i_cmp_key  (r_key),
            .o_key      (w_key[g]),
            .o_value    (w_value[g]),
            .o_valid    (w_valid[g]),
            .o_match    (w_match[g])
        );
    end

    // Assemble the result word; unused fields read as zero.
    always_comb begin
        n_out_data = '0;
        if (r_act == ACT_GET) begin
            n_out_data[0]    = w_found;
            n_out_data[32:1] = w_found ? w_mval : '0;
        end else begin
            n_out_data[33]     = w_full;
            n_out_data[65:34]  = w_full ? w_key[CELLS-1] : '0;
            n_out_data[97:66]  = w_full ? w_value[CELLS-1] : '0;
            n_out_data[98]     = w_matched;
            n_out_data[130:99] = w_matched ? w_mval : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_data};

    // Valid cells always form a contiguous run from the front.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("cell row has a hole in its valid run");

    // No new command is taken while a lookup is in flight.
    a_no_accept_in_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |-> !s_axis_tready)
        else $error("input accepted during lookup");

    // A finished update always presents a result word next cycle.
    a_upd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_go |=> m_axis_tvalid)
        else $error("update finished without a result word");

    // A lookup is always followed by its update.
    a_look_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> (r_state == ST_UPD))
        else $error("lookup not followed by update");

endmodule
